// ===== src/ttda_pkg.sv =====
// ttda_pkg: shared widths, codes and the evaluate-stage result type for the
// transposition table. No dependencies; used by ttda_eval and the top module.
package ttda_pkg;

    localparam int DEF_INDEX_BITS = 16;
    localparam int DEF_MOVE_BITS  = 16;

    localparam int KEY_W    = 64;
    localparam int DEPTH_W  = 8;
    localparam int SCORE_W  = 16;
    localparam int BOUND_W  = 2;
    localparam int AGE_W    = 6;
    localparam int IMOVE_W  = 16;

    localparam int IN_TDATA_W  = 112;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_TUSER_W = 2;

    localparam logic OP_PROBE = 1'b0;
    localparam logic OP_STORE = 1'b1;

    localparam logic [BOUND_W-1:0] BOUND_NONE = 2'b00;

    typedef struct packed {
        logic                 hit;
        logic                 written;
        logic                 wr_en;
        logic [DEPTH_W-1:0]   found_depth;
        logic [SCORE_W-1:0]   found_score;
        logic [BOUND_W-1:0]   found_bound;
        logic [AGE_W-1:0]     found_age;
        logic [IMOVE_W-1:0]   found_move;
    } eval_res_t;

endpackage

// ===== src/ttda_mem.sv =====
// ttda_mem: single-write, single-read synchronous slot memory, registered
// read. Generic; no package dependency.
module ttda_mem #(
    parameter int ADDR_W = 16,
    parameter int DATA_W = 112
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/ttda_eval.sv =====
// ttda_eval: hit test, depth/age replacement decision and new slot image.
// Depends on ttda_pkg.
module ttda_eval #(
    parameter int MOVE_BITS = ttda_pkg::DEF_MOVE_BITS,
    parameter int ENTRY_W   = ttda_pkg::KEY_W + MOVE_BITS + ttda_pkg::SCORE_W
                              + ttda_pkg::DEPTH_W + ttda_pkg::BOUND_W + ttda_pkg::AGE_W
) (
    input  logic [ENTRY_W-1:0]            entry,
    input  logic                          op,
    input  logic [ttda_pkg::KEY_W-1:0]    key,
    input  logic [ttda_pkg::DEPTH_W-1:0]  depth,
    input  logic [ttda_pkg::SCORE_W-1:0]  score,
    input  logic [ttda_pkg::BOUND_W-1:0]  bound,
    input  logic [ttda_pkg::IMOVE_W-1:0]  best_move,
    input  logic [ttda_pkg::AGE_W-1:0]    search_age,
    output ttda_pkg::eval_res_t           res,
    output logic [ENTRY_W-1:0]            wr_entry
);

    typedef struct packed {
        logic [ttda_pkg::KEY_W-1:0]   key;
        logic [MOVE_BITS-1:0]         mv;
        logic [ttda_pkg::SCORE_W-1:0] score;
        logic [ttda_pkg::DEPTH_W-1:0] depth;
        logic [ttda_pkg::BOUND_W-1:0] bound;
        logic [ttda_pkg::AGE_W-1:0]   age;
    } entry_t;

    entry_t      cur;
    entry_t      nxt;
    logic        key_eq;
    logic        occupied;
    logic        replace;
    logic [31:0] mv_in32;
    logic [31:0] mv_out32;

    assign cur      = entry_t'(entry);
    assign key_eq   = (cur.key == key);
    assign occupied = (cur.bound != ttda_pkg::BOUND_NONE);
    assign replace  = !occupied || key_eq || (cur.age != search_age) || (depth >= cur.depth);

    // move word is zero extended or truncated to the stored width
    assign mv_in32  = {16'b0, best_move};
    assign mv_out32 = 32'(cur.mv);

    always_comb
    begin
        nxt.key   = key;
        nxt.mv    = mv_in32[MOVE_BITS-1:0];
        nxt.score = score;
        nxt.depth = depth;
        nxt.bound = bound;
        nxt.age   = search_age;
        wr_entry  = ENTRY_W'(nxt);

        res = '0;
        if (op == ttda_pkg::OP_STORE)
        begin
            res.wr_en   = replace;
            res.written = replace;
        end
        else if (occupied && key_eq)
        begin
            res.hit         = 1'b1;
            res.found_depth = cur.depth;
            res.found_score = cur.score;
            res.found_bound = cur.bound;
            res.found_age   = cur.age;
            res.found_move  = mv_out32[15:0];
        end
    end

endmodule

// ===== src/transposition_table_depth_age_top.sv =====
// transposition_table_depth_age_top: direct-mapped transposition table with
// depth-preferred, age-aware replacement. Depends on ttda_pkg, ttda_mem, ttda_eval.
//
//  channel  | direction | handshake             | payload
//  s_axis   | in        | s_axis_tvalid/tready  | tuser op, tdata key..best_move
//  m_axis   | out       | m_axis_tvalid/tready  | tuser hit/written, tdata found_*
//  cfg      | in        | cfg_valid/cfg_ready   | cfg_data search_age
//
// One request per cycle sustained while the output is not stalled; slot read at the
// accepting edge, compare and write back with the result registered when the evaluate
// stage fires. Back-to-back requests to the same slot forward the written image.
// After reset a clearing pass zeroes the table; s_axis_tready stays low for its length.
// m_axis_tready low with a result pending holds evaluation and stops new requests.
module transposition_table_depth_age_top #(
    parameter int INDEX_BITS = ttda_pkg::DEF_INDEX_BITS,
    parameter int MOVE_BITS  = ttda_pkg::DEF_MOVE_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // key[63:0], depth[71:64], score[87:72], bound[89:88], best_move[105:90]
    input  logic [ttda_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // op
    input  logic                                 s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // found_depth[7:0], found_score[23:8], found_bound[25:24],
    // found_age[31:26], found_move[47:32]
    output logic [ttda_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // hit[0], written[1]
    output logic [ttda_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ttda_pkg::AGE_W-1:0]           cfg_data
);

    localparam int ENTRY_W = ttda_pkg::KEY_W + MOVE_BITS + ttda_pkg::SCORE_W
                             + ttda_pkg::DEPTH_W + ttda_pkg::BOUND_W + ttda_pkg::AGE_W;

    logic                           clr_active_reg;
    logic [INDEX_BITS-1:0]          clr_addr_reg;
    logic                           busy_reg;
    logic                           busy_next;
    logic                           fwd_reg;
    logic [ENTRY_W-1:0]             fwd_data_reg;
    logic [ttda_pkg::AGE_W-1:0]     age_reg;

    logic                           op_reg;
    logic [ttda_pkg::KEY_W-1:0]     key_reg;
    logic [ttda_pkg::DEPTH_W-1:0]   depth_reg;
    logic [ttda_pkg::SCORE_W-1:0]   score_reg;
    logic [ttda_pkg::BOUND_W-1:0]   bound_reg;
    logic [ttda_pkg::IMOVE_W-1:0]   move_reg;

    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [ttda_pkg::OUT_TDATA_W-1:0] out_data_reg;
    logic [ttda_pkg::OUT_TUSER_W-1:0] out_user_reg;

    logic                           in_fire;
    logic                           eval_fire;
    logic [INDEX_BITS-1:0]          in_idx;
    logic [INDEX_BITS-1:0]          cur_idx;
    logic [ENTRY_W-1:0]             rd_data;
    logic [ENTRY_W-1:0]             entry;
    logic [ENTRY_W-1:0]             wr_entry;
    ttda_pkg::eval_res_t            res;

    logic                           mem_we;
    logic [INDEX_BITS-1:0]          mem_waddr;
    logic [ENTRY_W-1:0]             mem_wdata;

    assign in_idx    = s_axis_tdata[INDEX_BITS-1:0];
    assign cur_idx   = key_reg[INDEX_BITS-1:0];
    assign eval_fire = busy_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !clr_active_reg && (!busy_reg || eval_fire);
    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign cfg_ready = 1'b1;

    assign entry = fwd_reg ? fwd_data_reg : rd_data;

    assign mem_we    = clr_active_reg || (eval_fire && res.wr_en);
    assign mem_waddr = clr_active_reg ? clr_addr_reg : cur_idx;
    assign mem_wdata = clr_active_reg ? '0 : wr_entry;

    ttda_mem #(
        .ADDR_W (INDEX_BITS),
        .DATA_W (ENTRY_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (in_fire),
        .raddr (in_idx),
        .rdata (rd_data)
    );

    ttda_eval #(
        .MOVE_BITS (MOVE_BITS),
        .ENTRY_W   (ENTRY_W)
    ) u_eval (
        .entry      (entry),
        .op         (op_reg),
        .key        (key_reg),
        .depth      (depth_reg),
        .score      (score_reg),
        .bound      (bound_reg),
        .best_move  (move_reg),
        .search_age (age_reg),
        .res        (res),
        .wr_entry   (wr_entry)
    );

    always_comb
    begin
        busy_next = busy_reg;
        if (in_fire)
        begin
            busy_next = 1'b1;
        end
        else if (eval_fire)
        begin
            busy_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (eval_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            busy_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            fwd_reg        <= 1'b0;
            age_reg        <= '0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (&clr_addr_reg)
                begin
                    clr_active_reg <= 1'b0;
                end
            end
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            if (in_fire)
            begin
                // same slot written at this edge: memory read returns the old image
                fwd_reg <= eval_fire && res.wr_en && (in_idx == cur_idx);
            end
            if (cfg_valid)
            begin
                age_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg       <= s_axis_tuser;
            key_reg      <= s_axis_tdata[63:0];
            depth_reg    <= s_axis_tdata[71:64];
            score_reg    <= s_axis_tdata[87:72];
            bound_reg    <= s_axis_tdata[89:88];
            move_reg     <= s_axis_tdata[105:90];
            fwd_data_reg <= wr_entry;
        end
        if (eval_fire)
        begin
            out_data_reg <= {res.found_move, res.found_age, res.found_bound,
                             res.found_score, res.found_depth};
            out_user_reg <= {res.written, res.hit};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    a_no_req_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !in_fire)
        else $error("request accepted during clearing pass");

    a_clear_writes: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> (mem_we && mem_wdata == '0))
        else $error("clearing pass skipped a slot");

    a_result_from_eval: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(busy_reg))
        else $error("result without request in flight");

    a_hit_xor_written: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("result both hit and written");

    a_write_only_store: assert property (@(posedge clk) disable iff (!rst_n)
        (eval_fire && res.wr_en) |-> (op_reg == ttda_pkg::OP_STORE))
        else $error("probe wrote the table");

endmodule
